>>> rtl/mvps_pkg.sv
// Package: shared constants, register map and config struct for the MV parity unit.
package mvps_pkg;

  // Default motion vector component width
  localparam int MV_BITS_DEF = 12;

  // Configuration port geometry
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_MODE          = 2'd0;
  localparam logic [1:0] REG_DUMMY_PASS    = 2'd1;
  localparam logic [1:0] REG_MIN_LENGTH    = 2'd2;
  localparam logic [1:0] REG_MAX_COMPONENT = 2'd3;

  // Field widths of the registers
  localparam int MIN_LEN_BITS = 10;
  localparam int MAX_CMP_BITS = 11;
  localparam int LIM_BITS     = MIN_LEN_BITS + 1;
  localparam int LIM_SQ_BITS  = 2 * LIM_BITS;

  // Reset values
  localparam logic [MIN_LEN_BITS-1:0] MIN_LENGTH_RST    = 10'd5;
  localparam logic [MAX_CMP_BITS-1:0] MAX_COMPONENT_RST = 11'd30;
  localparam logic [LIM_SQ_BITS-1:0]  LIM_SQ_RST        = LIM_SQ_BITS'(4 * 5 * 5);

  // Mode and item codes
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;
  localparam logic OP_VECTOR    = 1'b0;
  localparam logic OP_LOAD      = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic                    dummy_pass;
    logic [MIN_LEN_BITS-1:0] min_length;
    logic [MAX_CMP_BITS-1:0] max_component;
    logic [LIM_SQ_BITS-1:0]  lim_sq;
  } cfg_t;

endpackage

>>> rtl/mvps_in_if.sv
// Interface: input channel carrying vector or payload-load items.
interface mvps_in_if #(
  parameter int MV_BITS = mvps_pkg::MV_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [MV_BITS-1:0] mv_x;
  logic signed [MV_BITS-1:0] mv_y;
  logic [7:0]                payload_byte;

  modport source (output valid, op, mv_x, mv_y, payload_byte, input ready);
  modport sink   (input valid, op, mv_x, mv_y, payload_byte, output ready);
endinterface

>>> rtl/mvps_out_if.sv
// Interface: output channel carrying one result item per input item.
interface mvps_out_if #(
  parameter int MV_BITS = mvps_pkg::MV_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [MV_BITS:0] out_mv_x;
  logic signed [MV_BITS:0] out_mv_y;
  logic                    bit_taken;
  logic                    need_byte;
  logic [7:0]              byte_out;
  logic                    byte_valid;
  logic [31:0]             bit_count;

  modport source (output valid, out_mv_x, out_mv_y, bit_taken, need_byte, byte_out,
                  byte_valid, bit_count, input ready);
  modport sink   (input valid, out_mv_x, out_mv_y, bit_taken, need_byte, byte_out,
                  byte_valid, bit_count, output ready);
endinterface

>>> rtl/motion_vector_parity_stego_unit.sv
// Top level: motion vector parity embed/extract unit with input and result registers.
//
// Usage:
//   mv_in carries items: op 0 is a motion vector (mv_x, mv_y), op 1 loads
//   payload_byte as the next byte to embed (ignored in extract mode).
//   mv_out returns exactly one result item per input item, in order.
//   The APB-style port sets mode, dummy_pass, min_length and max_component
//   at byte addresses 0, 4, 8 and 12; write it only while no item is in flight.
// Datapath:
//   An accepted item lands in the input register, is evaluated by one stage of
//   logic (two 11-bit squares, a compare and two parity passes) and is written
//   to the result register when the stage advances, that is when that register
//   is free or its result is being taken.
//   Throughput is one item per cycle while the receiver keeps ready high.
// Reset (rst, synchronous): clears both stage valids, the payload byte, the bit
//   index and the bit counter, and loads register defaults (embed, no dummy
//   pass, min_length 5, max_component 30).
// Stall: when the receiver holds ready low the result register holds; the
//   input register still takes one more item, then ready drops until the
//   result is taken. Nothing is lost or repeated.
module motion_vector_parity_stego_unit #(
  parameter int MV_BITS = mvps_pkg::MV_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  mvps_in_if.sink                             mv_in,
  mvps_out_if.source                          mv_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mvps_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [mvps_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [mvps_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import mvps_pkg::*;

  localparam int OW = MV_BITS + 1;
  localparam int CW = (OW > MAX_CMP_BITS) ? OW : MAX_CMP_BITS;

  cfg_t cfg;

  // Input register
  logic                      s1_valid;
  logic                      s1_op;
  logic signed [MV_BITS-1:0] s1_x, s1_y;
  logic [7:0]                s1_byte;

  // Result register
  logic                 s2_valid;
  logic signed [OW-1:0] r_x, r_y;
  logic                 r_taken, r_need, r_bvalid;
  logic [7:0]           r_bout;
  logic [31:0]          r_count;

  // Block state
  logic [7:0]  data_byte, data_byte_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [31:0] bits_total, bits_total_next;

  // Stage evaluation
  logic                 advance;
  logic                 qual;
  logic signed [OW-1:0] x1, y1, xa, ya, xb, yb;
  logic                 want;
  logic [OW-1:0]        xbu, ybu, mag_xb, mag_yb;
  logic                 fits;
  logic                 pick_x_orig, sel_lsb;
  logic [7:0]           ext_byte;
  logic signed [OW-1:0] n_x, n_y;
  logic                 n_taken, n_need, n_bvalid;
  logic [7:0]           n_bout;

  mvps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the stage when the result register is free or being emptied
  assign advance      = s1_valid && (!s2_valid || mv_out.ready);
  assign mv_in.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (mv_in.ready) begin
      s1_valid <= mv_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_in.valid && mv_in.ready) begin
      s1_op   <= mv_in.op;
      s1_x    <= mv_in.mv_x;
      s1_y    <= mv_in.mv_y;
      s1_byte <= mv_in.payload_byte;
    end
  end

  mvps_qual #(.MV_BITS(MV_BITS)) u_qual (
    .mv_x          (s1_x),
    .mv_y          (s1_y),
    .max_component (cfg.max_component),
    .lim_sq        (cfg.lim_sq),
    .qualifies     (qual)
  );

  assign x1   = OW'(s1_x);
  assign y1   = OW'(s1_y);
  assign want = data_byte[bit_index];

  // Two embedding passes; the second re-selects on the first pass's output
  mvps_pass #(.W(OW)) u_pass_a (
    .x_in       (x1),
    .y_in       (y1),
    .want       (want),
    .dummy_pass (cfg.dummy_pass),
    .x_out      (xa),
    .y_out      (ya)
  );

  mvps_pass #(.W(OW)) u_pass_b (
    .x_in       (xa),
    .y_in       (ya),
    .want       (want),
    .dummy_pass (cfg.dummy_pass),
    .x_out      (xb),
    .y_out      (yb)
  );

  // Drop the bit if a pushed component left the allowed range
  assign xbu    = xb;
  assign ybu    = yb;
  assign mag_xb = xbu[OW-1] ? (~xbu + 1'b1) : xbu;
  assign mag_yb = ybu[OW-1] ? (~ybu + 1'b1) : ybu;
  assign fits   = (CW'(mag_xb) <= CW'(cfg.max_component)) &&
                  (CW'(mag_yb) <= CW'(cfg.max_component));

  // Extract side: selection on the received vector
  assign pick_x_orig = (!s1_y[MV_BITS-1] && (s1_y != '0)) ||
                       ((s1_x == '0) && (s1_y == '0));
  assign sel_lsb     = pick_x_orig ? s1_x[0] : s1_y[0];
  assign ext_byte    = data_byte | (8'(sel_lsb) << bit_index);

  always_comb begin
    data_byte_next  = data_byte;
    bit_index_next  = bit_index;
    bits_total_next = bits_total;
    n_x      = x1;
    n_y      = y1;
    n_taken  = 1'b0;
    n_need   = 1'b0;
    n_bout   = '0;
    n_bvalid = 1'b0;
    if (s1_op == OP_LOAD) begin
      if (cfg.mode == MODE_EMBED) begin
        data_byte_next = s1_byte;
      end
      n_x = '0;
      n_y = '0;
    end else if (qual) begin
      if (cfg.mode == MODE_EMBED) begin
        n_x = xb;
        n_y = yb;
        if (fits) begin
          n_taken         = 1'b1;
          bit_index_next  = bit_index + 3'd1;
          bits_total_next = bits_total + 32'd1;
          n_need          = (bit_index == 3'd7);
        end
      end else begin
        n_taken         = 1'b1;
        bit_index_next  = bit_index + 3'd1;
        bits_total_next = bits_total + 32'd1;
        if (bit_index == 3'd7) begin
          n_bout         = ext_byte;
          n_bvalid       = 1'b1;
          data_byte_next = '0;
        end else begin
          data_byte_next = ext_byte;
        end
      end
    end
  end

  // Commit state and result together when the stage advances
  always_ff @(posedge clk) begin
    if (rst) begin
      data_byte  <= '0;
      bit_index  <= '0;
      bits_total <= '0;
    end else if (advance) begin
      data_byte  <= data_byte_next;
      bit_index  <= bit_index_next;
      bits_total <= bits_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= 1'b1;
    end else if (mv_out.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_x      <= n_x;
      r_y      <= n_y;
      r_taken  <= n_taken;
      r_need   <= n_need;
      r_bout   <= n_bout;
      r_bvalid <= n_bvalid;
      r_count  <= bits_total_next;
    end
  end

  assign mv_out.valid      = s2_valid;
  assign mv_out.out_mv_x   = r_x;
  assign mv_out.out_mv_y   = r_y;
  assign mv_out.bit_taken  = r_taken;
  assign mv_out.need_byte  = r_need;
  assign mv_out.byte_out   = r_bout;
  assign mv_out.byte_valid = r_bvalid;
  assign mv_out.bit_count  = r_count;
endmodule

>>> rtl/mvps_cfg.sv
// Configuration registers behind the APB-style port.
module mvps_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mvps_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [mvps_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [mvps_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output mvps_pkg::cfg_t                      cfg
);
  import mvps_pkg::*;

  logic                   wr_en;
  logic [1:0]             reg_sel;
  logic [LIM_BITS-1:0]    lim_wr;
  logic [LIM_SQ_BITS-1:0] lim_sq_wr;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  // Precompute (2*min_length)^2 at write time
  assign lim_wr    = {pwdata[MIN_LEN_BITS-1:0], 1'b0};
  assign lim_sq_wr = lim_wr * lim_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_EMBED;
      cfg.dummy_pass    <= 1'b0;
      cfg.min_length    <= MIN_LENGTH_RST;
      cfg.max_component <= MAX_COMPONENT_RST;
      cfg.lim_sq        <= LIM_SQ_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MODE:          cfg.mode <= pwdata[0];
        REG_DUMMY_PASS:    cfg.dummy_pass <= pwdata[0];
        REG_MIN_LENGTH: begin
          cfg.min_length <= pwdata[MIN_LEN_BITS-1:0];
          cfg.lim_sq     <= lim_sq_wr;
        end
        REG_MAX_COMPONENT: cfg.max_component <= pwdata[MAX_CMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:          prdata = CFG_DATA_BITS'(cfg.mode);
      REG_DUMMY_PASS:    prdata = CFG_DATA_BITS'(cfg.dummy_pass);
      REG_MIN_LENGTH:    prdata = CFG_DATA_BITS'(cfg.min_length);
      REG_MAX_COMPONENT: prdata = CFG_DATA_BITS'(cfg.max_component);
      default:           prdata = '0;
    endcase
  end
endmodule

>>> rtl/mvps_qual.sv
// Vector qualification: length against the minimum and components against the limit.
module mvps_qual #(
  parameter int MV_BITS = mvps_pkg::MV_BITS_DEF
) (
  input  logic signed [MV_BITS-1:0]              mv_x,
  input  logic signed [MV_BITS-1:0]              mv_y,
  input  logic [mvps_pkg::MAX_CMP_BITS-1:0]      max_component,
  input  logic [mvps_pkg::LIM_SQ_BITS-1:0]       lim_sq,
  output logic                                   qualifies
);
  import mvps_pkg::*;

  localparam int MW = (MV_BITS > MAX_CMP_BITS) ? MV_BITS : MAX_CMP_BITS;

  logic [MV_BITS-1:0]      xu, yu, mag_x, mag_y;
  logic                    in_lim_x, in_lim_y;
  logic [MAX_CMP_BITS-1:0] ax, ay;
  logic [LIM_SQ_BITS-1:0]  sq_x, sq_y;
  logic [LIM_SQ_BITS:0]    len_sq;

  assign xu    = mv_x;
  assign yu    = mv_y;
  assign mag_x = xu[MV_BITS-1] ? (~xu + 1'b1) : xu;
  assign mag_y = yu[MV_BITS-1] ? (~yu + 1'b1) : yu;

  assign in_lim_x = MW'(mag_x) <= MW'(max_component);
  assign in_lim_y = MW'(mag_y) <= MW'(max_component);

  // Within the limit a magnitude fits the 11-bit squarer; otherwise it fails anyway
  assign ax = in_lim_x ? MAX_CMP_BITS'(mag_x) : '0;
  assign ay = in_lim_y ? MAX_CMP_BITS'(mag_y) : '0;

  assign sq_x   = ax * ax;
  assign sq_y   = ay * ay;
  assign len_sq = {1'b0, sq_x} + {1'b0, sq_y};

  assign qualifies = in_lim_x & in_lim_y & (len_sq >= {1'b0, lim_sq});
endmodule

>>> rtl/mvps_pass.sv
// One embedding pass: select a component and push it off zero on a parity mismatch.
module mvps_pass #(
  parameter int W = mvps_pkg::MV_BITS_DEF + 1
) (
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic                want,
  input  logic                dummy_pass,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out
);
  logic               pick_x;
  logic signed [W-1:0] c, c_new;
  logic               change;
  logic               positive;

  assign pick_x   = (!y_in[W-1] && (y_in != '0)) || ((x_in == '0) && (y_in == '0));
  assign c        = pick_x ? x_in : y_in;
  assign change   = (c[0] ^ want) & ~dummy_pass;
  assign positive = !c[W-1] && (c != '0);
  assign c_new    = positive ? (c + W'(1)) : (c - W'(1));

  always_comb begin
    x_out = x_in;
    y_out = y_in;
    if (change) begin
      if (pick_x) begin
        x_out = c_new;
      end else begin
        y_out = c_new;
      end
    end
  end
endmodule

>>> verif/tb_top.sv
// Testbench for the motion vector parity unit: directed and random items checked against a predictor.
module tb_top;
  import mvps_pkg::*;

  localparam int MV_BITS    = MV_BITS_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 195;
  localparam int LONG_HOLD  = 80;

  // One input item and one result item, at the widths of the channels.
  typedef struct packed {
    logic                      op;
    logic signed [MV_BITS-1:0] mv_x;
    logic signed [MV_BITS-1:0] mv_y;
    logic [7:0]                payload_byte;
  } mv_item_t;

  typedef struct packed {
    logic signed [MV_BITS:0] out_mv_x;
    logic signed [MV_BITS:0] out_mv_y;
    logic                    bit_taken;
    logic                    need_byte;
    logic [7:0]              byte_out;
    logic                    byte_valid;
    logic [31:0]             bit_count;
  } mv_result_t;

  // Tracks register settings and payload state, predicts the result of every
  // accepted item and checks results in order against those predictions.
  class stego_scoreboard;
    logic                    mode;
    logic                    dummy_pass;
    logic [MIN_LEN_BITS-1:0] min_length;
    logic [MAX_CMP_BITS-1:0] max_component;
    logic [7:0]              data_byte;
    logic [2:0]              bit_index;
    logic [31:0]             bits_total;
    mv_result_t              stego_results[$];
    int                      mismatches;

    function new();
      mode          = MODE_EMBED;
      dummy_pass    = 1'b0;
      min_length    = MIN_LENGTH_RST;
      max_component = MAX_COMPONENT_RST;
      data_byte     = '0;
      bit_index     = '0;
      bits_total    = '0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE:          mode = val[0];
        REG_DUMMY_PASS:    dummy_pass = val[0];
        REG_MIN_LENGTH:    min_length = val[MIN_LEN_BITS-1:0];
        REG_MAX_COMPONENT: max_component = val[MAX_CMP_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    // x carries the bit when y is positive or the vector is zero.
    function bit x_selected(int x, int y);
      return (y > 0) || (x == 0 && y == 0);
    endfunction

    // Push the component away from zero when its LSB disagrees with the bit and dummy_pass is clear.
    function int parity_push(int c);
      if ((data_byte[bit_index] != c[0]) && !dummy_pass)
        c = (c > 0) ? c + 1 : c - 1;
      return c;
    endfunction

    function void note_item(mv_item_t it);
      int         x;
      int         y;
      int         c;
      longint     len2;
      longint     lim;
      mv_result_t r;
      x    = int'($signed(it.mv_x));
      y    = int'($signed(it.mv_y));
      r    = '0;
      len2 = longint'(x) * x + longint'(y) * y;
      lim  = 2 * longint'(min_length);
      if (it.op == OP_LOAD) begin
        if (mode == MODE_EMBED) data_byte = it.payload_byte;
        x = 0;
        y = 0;
      end else if (len2 >= lim * lim && mag(x) <= int'(max_component) &&
                   mag(y) <= int'(max_component)) begin
        if (mode == MODE_EMBED) begin
          repeat (2) begin
            if (x_selected(x, y)) x = parity_push(x);
            else y = parity_push(y);
          end
          if (mag(x) <= int'(max_component) && mag(y) <= int'(max_component)) begin
            r.bit_taken = 1'b1;
            bit_index   = bit_index + 3'd1;
            bits_total  = bits_total + 32'd1;
            r.need_byte = (bit_index == 3'd0);
          end
        end else begin
          c = x_selected(x, y) ? x : y;
          data_byte[bit_index] = data_byte[bit_index] | c[0];
          r.bit_taken = 1'b1;
          bit_index   = bit_index + 3'd1;
          bits_total  = bits_total + 32'd1;
          if (bit_index == 3'd0) begin
            r.byte_out   = data_byte;
            r.byte_valid = 1'b1;
            data_byte    = '0;
          end
        end
      end
      r.out_mv_x  = (MV_BITS + 1)'(x);
      r.out_mv_y  = (MV_BITS + 1)'(y);
      r.bit_count = bits_total;
      stego_results.push_back(r);
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_item(mv_result_t got);
      mv_result_t want;
      if (stego_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, got x %0d y %0d", $time,
                 $signed(got.out_mv_x), $signed(got.out_mv_y));
        return;
      end
      want = stego_results.pop_front();
      check_field("out_mv_x", longint'($signed(want.out_mv_x)),
                  longint'($signed(got.out_mv_x)));
      check_field("out_mv_y", longint'($signed(want.out_mv_y)),
                  longint'($signed(got.out_mv_y)));
      check_field("bit_taken", longint'(want.bit_taken), longint'(got.bit_taken));
      check_field("need_byte", longint'(want.need_byte), longint'(got.need_byte));
      check_field("byte_out", longint'(want.byte_out), longint'(got.byte_out));
      check_field("byte_valid", longint'(want.byte_valid), longint'(got.byte_valid));
      check_field("bit_count", longint'(want.bit_count), longint'(got.bit_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  mvps_in_if  #(.MV_BITS(MV_BITS)) mv_in();
  mvps_out_if #(.MV_BITS(MV_BITS)) mv_out();

  motion_vector_parity_stego_unit #(.MV_BITS(MV_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .mv_in   (mv_in),
    .mv_out  (mv_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stego_scoreboard tracker = new();

  int src_idle_pct;
  int snk_stall_pct;
  int holds_asked;
  int holds_seen;
  int hold_left;
  int cycle_count;

  // Per phase: mode, dummy_pass, min_length, max_component, sender idle %, receiver stall %.
  // The list walks through the register extremes: zero and near-full limits, the
  // longest minimum length, a zero component limit and a tiny one that makes
  // pushed components overflow.
  int phase_plan [PHASES][6] = '{
    '{0, 0,    5,   30,  0,  0},
    '{0, 0,    0, 2046, 54,  0},
    '{1, 0,    0, 2046,  0, 54},
    '{0, 1,    3,  100, 30, 30},
    '{1, 0, 1023, 2046,  0,  0},
    '{0, 0, 1023, 2046, 54,  0},
    '{1, 0,    0,    0,  0, 54},
    '{0, 0,    2,    7, 30, 30},
    '{0, 0,    0,    0,  0,  0},
    '{1, 1,    5,   30, 54,  0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort the run if it takes far longer than the slowest correct run could.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive ready: random stalls at the phase rate, plus a long hold-off
  // whenever the stimulus asks for one. The hold is counted here so the
  // sender keeps offering items while the unit backs up.
  always @(posedge clk) begin
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left  = LONG_HOLD;
    end
    if (rst || hold_left > 0) begin
      mv_out.ready <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else begin
      mv_out.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Check every result taken from the unit against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    mv_result_t got;
    if (!rst && mv_out.valid && mv_out.ready) begin
      got.out_mv_x   = mv_out.out_mv_x;
      got.out_mv_y   = mv_out.out_mv_y;
      got.bit_taken  = mv_out.bit_taken;
      got.need_byte  = mv_out.need_byte;
      got.byte_out   = mv_out.byte_out;
      got.byte_valid = mv_out.byte_valid;
      got.bit_count  = mv_out.bit_count;
      tracker.check_item(got);
    end
  end

  // Write one register through a setup and an access phase, then idle
  // the port so back-to-back writes never collide on one edge.
  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Offer one item, idling first at the phase rate; return at the edge
  // that accepts it, with valid still high.
  task automatic send_item(input mv_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      mv_in.valid <= 1'b0;
      @(posedge clk);
    end
    mv_in.valid        <= 1'b1;
    mv_in.op           <= it.op;
    mv_in.mv_x         <= it.mv_x;
    mv_in.mv_y         <= it.mv_y;
    mv_in.payload_byte <= it.payload_byte;
    @(posedge clk);
    while (!mv_in.ready) @(posedge clk);
    tracker.note_item(it);
  endtask

  // Drop valid and hold until every predicted result has come back, then
  // give the pipeline its latency before touching registers.
  task automatic drain_results();
    mv_in.valid <= 1'b0;
    while (tracker.stego_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic mv_item_t vec(int x, int y);
    mv_item_t it;
    it.op           = OP_VECTOR;
    it.mv_x         = MV_BITS'(x);
    it.mv_y         = MV_BITS'(y);
    it.payload_byte = 8'($urandom);
    return it;
  endfunction

  function automatic mv_item_t byte_load(logic [7:0] b);
    mv_item_t it;
    it.op           = OP_LOAD;
    it.mv_x         = MV_BITS'($urandom);
    it.mv_y         = MV_BITS'($urandom);
    it.payload_byte = b;
    return it;
  endfunction

  function automatic int in_box(int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic int rsign(int v);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random item: mostly vectors inside the component box, a share aimed at
  // the qualification edges, some raw full-range vectors, and byte loads
  // often enough in embed mode to keep fresh payload coming.
  function automatic mv_item_t make_item();
    mv_item_t it;
    int m;
    int lim;
    int roll;
    m    = int'(tracker.max_component);
    lim  = 2 * int'(tracker.min_length);
    it   = vec($urandom, $urandom);
    roll = $urandom_range(99);
    if (roll < ((tracker.mode == MODE_EMBED) ? 11 : 4)) begin
      it = byte_load(8'($urandom));
    end else if (roll < 75) begin
      it = vec(in_box(m), in_box(m));
    end else if (roll < 92) begin
      case ($urandom_range(5))
        0: it = vec(rsign(m), in_box(m));
        1: it = vec(in_box(m), rsign(m + 1));
        2: it = vec(0, 0);
        3: it = vec(rsign(lim - int'($urandom_range(1))), rsign($urandom_range(1)));
        4: it = vec(in_box(m), 0);
        default: it = vec(rsign($urandom_range(1)), in_box(m));
      endcase
    end
    return it;
  endfunction

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    mv_in.valid        = 1'b0;
    mv_in.op           = OP_VECTOR;
    mv_in.mv_x         = '0;
    mv_in.mv_y         = '0;
    mv_in.payload_byte = '0;
    mv_out.ready       = 1'b0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    holds_asked        = 0;
    holds_seen         = 0;
    hold_left          = 0;
    cycle_count        = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset settings (embed, min_length 5, max 30).
    send_item(byte_load(8'hA5));
    send_item(vec(10, 10));
    send_item(vec(-10, -10));
    send_item(vec(30, 30));        // at the limit: a push overflows and skips the bit
    send_item(vec(-30, -30));
    send_item(vec(30, -1));        // y not positive: y carries the bit
    send_item(vec(12, 0));         // y zero and not positive: y carries the bit
    send_item(vec(0, 0));          // zero vector fails the length test
    send_item(vec(2047, 2047));
    send_item(vec(-2048, -2048));
    send_item(vec(3, 4));          // too short
    send_item(vec(10, 0));         // exactly on the length threshold
    send_item(vec(0, -10));
    send_item(vec(31, 0));         // component over the limit
    send_item(byte_load(8'h00));
    send_item(vec(29, 29));
    send_item(vec(-29, 29));
    send_item(byte_load(8'hFF));
    send_item(vec(15, -20));
    send_item(vec(-1, 25));
    send_item(vec(-2048, 2047));
    send_item(vec(2047, -2048));
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_MODE, phase_plan[p][0]);
      write_reg(REG_DUMMY_PASS, phase_plan[p][1]);
      write_reg(REG_MIN_LENGTH, phase_plan[p][2]);
      write_reg(REG_MAX_COMPONENT, phase_plan[p][3]);
      src_idle_pct  = phase_plan[p][4];
      snk_stall_pct = phase_plan[p][5];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In the first phase, stall the receiver long enough to back the
        // unit up, and later pause the sender until everything is back.
        if (p == 0 && n == 40) holds_asked++;
        if (p == 0 && n == 120) drain_results();
        send_item(make_item());
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.stego_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
